>>> src/i3ag_pkg.sv
// i3ag_pkg: shared types, widths and helpers for the 3-D im2col address generator.
// No dependencies; every other file in src/ imports it.
`default_nettype none

package i3ag_pkg;

  localparam int DEF_KERNEL_FIELD_BITS = 8;
  localparam int DEF_MAX_BATCH         = 256;

  localparam int BATCH_W   = 8;
  localparam int ROW_W     = 24;
  localparam int POS_W     = 10;
  localparam int SRC_W     = 48;
  localparam int DST_W     = 63;
  localparam int DIM_W     = 11;
  localparam int PACK_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int HW_W      = 2 * DIM_W;
  localparam int DHW_W     = 3 * DIM_W;

  // dimension lanes inside packed per-dimension vectors
  localparam int DIM_DEP = 0;
  localparam int DIM_ROW = 1;
  localparam int DIM_COL = 2;

  // shared divider step: 16-bit divisor, 24-bit dividend, DIV_BPS quotient bits per call
  localparam int DIV_D_W    = 16;
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = ROW_W / DIV_BPS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_IMAGE_DEPTH   = 3'd1,
    REG_IMAGE_HEIGHT  = 3'd2,
    REG_IMAGE_WIDTH   = 3'd3,
    REG_KERNEL_SIZES  = 3'd4,
    REG_STRIDES       = 3'd5,
    REG_PADDINGS      = 3'd6,
    REG_DILATIONS     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0]  channel_count;
    logic [DIM_W-1:0]  image_depth;
    logic [DIM_W-1:0]  image_height;
    logic [DIM_W-1:0]  image_width;
    logic [PACK_W-1:0] kernel_sizes;
    logic [PACK_W-1:0] strides;
    logic [PACK_W-1:0] paddings;
    logic [PACK_W-1:0] dilations;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    channel_count: 11'd1,
    image_depth:   11'd1,
    image_height:  11'd1,
    image_width:   11'd1,
    kernel_sizes:  24'h010101,
    strides:       24'h010101,
    paddings:      24'h000000,
    dilations:     24'h010101
  };

  typedef struct packed {
    logic [DIV_D_W-1:0] rem;
    logic [ROW_W-1:0]   dq;   // dividend shifting out, quotient shifting in
  } div_t;

  // width of an output extent (also of the positive extent numerator)
  function automatic int ext_width(int k);
    return ((DIM_W > k + 1) ? DIM_W : k + 1) + 1;
  endfunction

  function automatic int rows_width(int k);
    return DIM_W + 3 * k;
  endfunction

  // DIV_BPS restoring division steps
  function automatic div_t div_steps(div_t a, logic [DIV_D_W-1:0] d);
    div_t            r;
    logic [DIV_D_W:0] t;
    r = a;
    for (int i = 0; i < DIV_BPS; i++) begin
      t    = {r.rem, r.dq[ROW_W-1]};
      r.dq = {r.dq[ROW_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t       = t - {1'b0, d};
        r.dq[0] = 1'b1;
      end
      r.rem = t[DIV_D_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/i3ag_if.sv
// i3ag_req_if / i3ag_rsp_if: valid/ready channels for request and result beats.
// Depends on i3ag_pkg for the payload widths.
`default_nettype none

interface i3ag_req_if import i3ag_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [BATCH_W-1:0] batch_index;
  logic [ROW_W-1:0]   column_row;
  logic [POS_W-1:0]   out_depth;
  logic [POS_W-1:0]   out_row;
  logic [POS_W-1:0]   out_col;

  modport source (output valid, batch_index, column_row, out_depth, out_row, out_col,
                  input ready);
  modport sink   (input valid, batch_index, column_row, out_depth, out_row, out_col,
                  output ready);
endinterface

interface i3ag_rsp_if import i3ag_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] source_address;
  logic [DST_W-1:0] dest_address;
  logic             inside_image;
  logic             request_error;

  modport source (output valid, source_address, dest_address, inside_image, request_error,
                  input ready);
  modport sink   (input valid, source_address, dest_address, inside_image, request_error,
                  output ready);
endinterface

`default_nettype wire

>>> src/i3ag_cfg_derive.sv
// i3ag_cfg_derive: free-running chain that turns the configuration registers into
// kernel fields, output extents and plane/volume sizes. Depends on i3ag_pkg.
`default_nettype none

module i3ag_cfg_derive import i3ag_pkg::*; #(
  parameter int KERNEL_FIELD_BITS = DEF_KERNEL_FIELD_BITS,
  localparam int K       = KERNEL_FIELD_BITS,
  localparam int EXT_W   = ext_width(KERNEL_FIELD_BITS),
  localparam int ROWS_W  = rows_width(KERNEL_FIELD_BITS)
) (
  input  logic                  clk,
  input  cfg_regs_t             cfg,
  output logic [2:0][K-1:0]     ksize,
  output logic [2:0][K-1:0]     stride,
  output logic [2:0][K-1:0]     pad,
  output logic [2:0][K-1:0]     dil,
  output logic [HW_W-1:0]       hw,
  output logic [DHW_W-1:0]      dhw,
  output logic [ROWS_W-1:0]     rows,
  output logic [2:0][EXT_W-1:0] ext,
  output logic [2*EXT_W-1:0]    hw_col,
  output logic [3*EXT_W-1:0]    dhw_col
);

  localparam int NUM_W = EXT_W;
  localparam int NSW   = 2 * K + DIM_W + 3;

  logic [2:0][DIM_W-1:0] dims;
  logic [2:0][2*K-1:0]   dk;
  logic [2:0][NSW-1:0]   num;
  logic [2:0]            ok;
  logic [2*K-1:0]        kdkr;
  logic [3*K-1:0]        kvol;
  div_t                  dvs [3][DIV_STAGES+1];

  function automatic logic [K-1:0] field(logic [PACK_W-1:0] r, int which);
    logic [3*K+PACK_W-1:0] x;
    x = (3*K+PACK_W)'(r);
    return x[which*K +: K];
  endfunction

  assign dims[DIM_DEP] = cfg.image_depth;
  assign dims[DIM_ROW] = cfg.image_height;
  assign dims[DIM_COL] = cfg.image_width;

  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      ksize[d]  <= field(cfg.kernel_sizes, d);
      // stride field of zero acts as one
      stride[d] <= (field(cfg.strides, d) == '0) ? K'(1) : field(cfg.strides, d);
      pad[d]    <= field(cfg.paddings, d);
      dil[d]    <= field(cfg.dilations, d);
      dk[d]     <= (2*K)'(dil[d]) * (2*K)'(ksize[d] - K'(1));
      num[d]    <= NSW'(dims[d]) + NSW'({pad[d], 1'b0}) - NSW'(dk[d]) - NSW'(1);
      ok[d]     <= (ksize[d] != '0) && !num[d][NSW-1];
      ext[d]    <= ok[d] ? EXT_W'(dvs[d][DIV_STAGES].dq + ROW_W'(1)) : '0;
    end
    hw      <= HW_W'(cfg.image_height) * HW_W'(cfg.image_width);
    dhw     <= DHW_W'(cfg.image_depth) * DHW_W'(hw);
    kdkr    <= (2*K)'(ksize[DIM_DEP]) * (2*K)'(ksize[DIM_ROW]);
    kvol    <= (3*K)'(kdkr) * (3*K)'(ksize[DIM_COL]);
    rows    <= ROWS_W'(cfg.channel_count) * ROWS_W'(kvol);
    hw_col  <= (2*EXT_W)'(ext[DIM_ROW]) * (2*EXT_W)'(ext[DIM_COL]);
    dhw_col <= (3*EXT_W)'(ext[DIM_DEP]) * (3*EXT_W)'(hw_col);
  end

  for (genvar d = 0; d < 3; d++) begin : g_lane
    always_ff @(posedge clk) begin
      dvs[d][0] <= '{rem: '0, dq: ROW_W'(num[d][NUM_W-1:0])};
    end
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
      always_ff @(posedge clk) begin
        dvs[d][j+1] <= div_steps(dvs[d][j], DIV_D_W'(stride[d]));
      end
    end
  end

endmodule

`default_nettype wire

>>> src/im2col_3d_address_generator.sv
// Pipelined 3-D im2col (vol2col) address generator: one request beat in, one result
// beat out per cycle while the result is not stalled. The pipeline is built around the
// chained division of column_row by kernel cols, rows and depth: three 24-bit dividers
// of six stages each, four quotient bits per stage, followed by multiply, tap,
// partial-product and summing stages. Every stage holds its beat while the next one
// is full and stalled, so a stalled result holds no bubbles and the input keeps
// accepting until the pipe is full. Extents and sizes derived from the configuration
// are registered in i3ag_cfg_derive after a register write; configuration must only be
// written while no beat is in flight. Depends on i3ag_pkg, i3ag_if and i3ag_cfg_derive.
`default_nettype none

module im2col_3d_address_generator import i3ag_pkg::*; #(
  parameter int MAX_BATCH         = DEF_MAX_BATCH,
  parameter int KERNEL_FIELD_BITS = DEF_KERNEL_FIELD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  i3ag_req_if.sink             req,
  i3ag_rsp_if.source           rsp,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PACK_W-1:0]    cfg_data
);

  localparam int K         = KERNEL_FIELD_BITS;
  localparam int EXT_W     = ext_width(K);
  localparam int ROWS_W    = rows_width(K);
  localparam int CMP_W     = (ROWS_W > ROW_W) ? ROWS_W : ROW_W;
  localparam int BCMP_W    = 17;
  localparam int PA_W      = POS_W + K;
  localparam int PB_W      = 2 * K;
  localparam int TAP_W     = ((PA_W > PB_W) ? PA_W : PB_W) + 2;
  localparam int BROWS_W   = BATCH_W + ROWS_W;
  localparam int ROWG_W    = (BROWS_W + 1 < DST_W) ? BROWS_W + 1 : DST_W;
  localparam int BC_W      = BATCH_W + DIM_W;
  localparam int OD_HW_W   = POS_W + 2 * EXT_W;
  localparam int OH_EW_W   = POS_W + EXT_W;
  localparam int DLOW_W    = OD_HW_W + 2;
  localparam int DHWC_W    = 3 * EXT_W;
  localparam int CHUNK     = 16;
  localparam int NCH       = (ROWG_W + CHUNK - 1) / CHUNK;
  localparam int PP_W      = CHUNK + DHWC_W;
  localparam int SPLIT     = 17;
  localparam int SP0_W     = BC_W + SPLIT;
  localparam int SP1_W     = BC_W + DHW_W - SPLIT;
  localparam int IDHW_W    = DIM_W + HW_W;
  localparam int IHW_W     = 2 * DIM_W;

  localparam int DIV_TOTAL = 3 * DIV_STAGES;
  localparam int S_MUL     = DIV_TOTAL + 1;
  localparam int S_TAP     = DIV_TOTAL + 2;
  localparam int S_PP      = DIV_TOTAL + 3;
  localparam int S_SUM     = DIV_TOTAL + 4;
  localparam int N         = S_SUM + 1;

  typedef struct packed {
    logic [BATCH_W-1:0]         b;
    logic [ROW_W-1:0]           row;
    logic [2:0][POS_W-1:0]      pos;
    div_t                       dv;
    logic [2:0][K-1:0]          off;
    logic [DIM_W-1:0]           ci;
    logic                       err;
    logic [2:0][PA_W-1:0]       pa;
    logic [2:0][PB_W-1:0]       pb;
    logic [BROWS_W-1:0]         brows;
    logic [BC_W-1:0]            bc;
    logic [OD_HW_W-1:0]         od_hw;
    logic [OH_EW_W-1:0]         oh_ew;
    logic [2:0][TAP_W-1:0]      tap;
    logic [ROWG_W-1:0]          rowg;
    logic [BC_W-1:0]            bci;
    logic [DLOW_W-1:0]          dlow;
    logic                       in_img;
    logic [NCH-1:0][PP_W-1:0]   pp;
    logic [SP0_W-1:0]           sp0;
    logic [SP1_W-1:0]           sp1;
    logic [IDHW_W-1:0]          idhw;
    logic [IHW_W-1:0]           ihw;
    logic [SRC_W-1:0]           src;
    logic [DST_W-1:0]           dst;
  } item_t;

  cfg_regs_t             cfg;
  logic [2:0][DIM_W-1:0] dims;
  logic [2:0][K-1:0]     ksize, stride, pad, dil;
  logic [HW_W-1:0]       hw;
  logic [DHW_W-1:0]      dhw;
  logic [ROWS_W-1:0]     rows;
  logic [2:0][EXT_W-1:0] ext;
  logic [2*EXT_W-1:0]    hw_col;
  logic [DHWC_W-1:0]     dhw_col;

  logic [N-1:0]          v;
  logic [N:0]            en;
  item_t                 pipe [N];
  item_t                 nxt  [N];
  logic [NCH*CHUNK-1:0]  rowg_pad;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[DIM_W-1:0];
        REG_IMAGE_DEPTH:   cfg.image_depth   <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[DIM_W-1:0];
        REG_KERNEL_SIZES:  cfg.kernel_sizes  <= cfg_data;
        REG_STRIDES:       cfg.strides       <= cfg_data;
        REG_PADDINGS:      cfg.paddings      <= cfg_data;
        REG_DILATIONS:     cfg.dilations     <= cfg_data;
      endcase
    end
  end

  assign dims[DIM_DEP] = cfg.image_depth;
  assign dims[DIM_ROW] = cfg.image_height;
  assign dims[DIM_COL] = cfg.image_width;

  i3ag_cfg_derive #(
    .KERNEL_FIELD_BITS (KERNEL_FIELD_BITS)
  ) u_derive (
    .clk     (clk),
    .cfg     (cfg),
    .ksize   (ksize),
    .stride  (stride),
    .pad     (pad),
    .dil     (dil),
    .hw      (hw),
    .dhw     (dhw),
    .rows    (rows),
    .ext     (ext),
    .hw_col  (hw_col),
    .dhw_col (dhw_col)
  );

  // per-stage flow control: a stage loads when empty or when its beat moves on
  assign en[N] = rsp.ready;
  for (genvar s = 0; s < N; s++) begin : g_en
    assign en[s] = !v[s] || en[s+1];
  end
  assign req.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < N; s++) begin
        if (en[s]) begin
          v[s] <= (s == 0) ? req.valid : v[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en[s]) begin
        pipe[s] <= nxt[s];
      end
    end
  end

  always_comb begin
    nxt[0]               = '0;
    nxt[0].b             = req.batch_index;
    nxt[0].row           = req.column_row;
    nxt[0].pos[DIM_DEP]  = req.out_depth;
    nxt[0].pos[DIM_ROW]  = req.out_row;
    nxt[0].pos[DIM_COL]  = req.out_col;
    nxt[0].dv.dq         = req.column_row;
  end

  assign rowg_pad = (NCH*CHUNK)'(pipe[S_PP-1].rowg);

  for (genvar s = 1; s < N; s++) begin : g_stage
    if (s <= DIV_TOTAL) begin : g_div
      // divide by kernel cols, then rows, then depth; each remainder is one offset
      localparam int DI   = (s - 1) / DIV_STAGES;
      localparam int SI   = (s - 1) % DIV_STAGES;
      localparam int PREV = (DI > 0) ? 3 - DI : 0;
      always_comb begin
        nxt[s] = pipe[s-1];
        if (SI == 0 && DI > 0) begin
          nxt[s].off[PREV] = pipe[s-1].dv.rem[K-1:0];
          nxt[s].dv.rem    = '0;
        end
        nxt[s].dv = div_steps(nxt[s].dv, DIV_D_W'(ksize[2-DI]));
      end
    end else if (s == S_MUL) begin : g_mul
      always_comb begin
        nxt[s]              = pipe[s-1];
        nxt[s].off[DIM_DEP] = pipe[s-1].dv.rem[K-1:0];
        nxt[s].ci           = pipe[s-1].dv.dq[DIM_W-1:0];
        nxt[s].err = (BCMP_W'(pipe[s-1].b) >= BCMP_W'(MAX_BATCH))
                  || (CMP_W'(pipe[s-1].row) >= CMP_W'(rows))
                  || (EXT_W'(pipe[s-1].pos[DIM_DEP]) >= ext[DIM_DEP])
                  || (EXT_W'(pipe[s-1].pos[DIM_ROW]) >= ext[DIM_ROW])
                  || (EXT_W'(pipe[s-1].pos[DIM_COL]) >= ext[DIM_COL]);
        for (int d = 0; d < 3; d++) begin
          nxt[s].pa[d] = PA_W'(pipe[s-1].pos[d]) * PA_W'(stride[d]);
          nxt[s].pb[d] = PB_W'(nxt[s].off[d]) * PB_W'(dil[d]);
        end
        nxt[s].brows = BROWS_W'(pipe[s-1].b) * BROWS_W'(rows);
        nxt[s].bc    = BC_W'(pipe[s-1].b) * BC_W'(cfg.channel_count);
        nxt[s].od_hw = OD_HW_W'(pipe[s-1].pos[DIM_DEP]) * OD_HW_W'(hw_col);
        nxt[s].oh_ew = OH_EW_W'(pipe[s-1].pos[DIM_ROW]) * OH_EW_W'(ext[DIM_COL]);
      end
    end else if (s == S_TAP) begin : g_tap
      always_comb begin
        nxt[s] = pipe[s-1];
        for (int d = 0; d < 3; d++) begin
          nxt[s].tap[d] = TAP_W'(pipe[s-1].pa[d]) - TAP_W'(pad[d]) + TAP_W'(pipe[s-1].pb[d]);
        end
        nxt[s].rowg = ROWG_W'(pipe[s-1].brows) + ROWG_W'(pipe[s-1].row);
        nxt[s].bci  = pipe[s-1].bc + BC_W'(pipe[s-1].ci);
        nxt[s].dlow = DLOW_W'(pipe[s-1].od_hw) + DLOW_W'(pipe[s-1].oh_ew)
                    + DLOW_W'(pipe[s-1].pos[DIM_COL]);
      end
    end else if (s == S_PP) begin : g_pp
      always_comb begin
        nxt[s]        = pipe[s-1];
        nxt[s].in_img = 1'b1;
        for (int d = 0; d < 3; d++) begin
          if (pipe[s-1].tap[d][TAP_W-1] || (pipe[s-1].tap[d] >= TAP_W'(dims[d]))) begin
            nxt[s].in_img = 1'b0;
          end
        end
        for (int i = 0; i < NCH; i++) begin
          nxt[s].pp[i] = PP_W'(rowg_pad[i*CHUNK +: CHUNK]) * PP_W'(dhw_col);
        end
        nxt[s].sp0  = SP0_W'(pipe[s-1].bci) * SP0_W'(dhw[SPLIT-1:0]);
        nxt[s].sp1  = SP1_W'(pipe[s-1].bci) * SP1_W'(dhw[DHW_W-1:SPLIT]);
        nxt[s].idhw = IDHW_W'(pipe[s-1].tap[DIM_DEP][DIM_W-1:0]) * IDHW_W'(hw);
        nxt[s].ihw  = IHW_W'(pipe[s-1].tap[DIM_ROW][DIM_W-1:0]) * IHW_W'(cfg.image_width);
      end
    end else begin : g_sum
      always_comb begin
        nxt[s]     = pipe[s-1];
        nxt[s].src = SRC_W'(pipe[s-1].sp0) + (SRC_W'(pipe[s-1].sp1) << SPLIT)
                   + SRC_W'(pipe[s-1].idhw) + SRC_W'(pipe[s-1].ihw)
                   + SRC_W'(pipe[s-1].tap[DIM_COL][DIM_W-1:0]);
        nxt[s].dst = DST_W'(pipe[s-1].dlow);
        for (int i = 0; i < NCH; i++) begin
          nxt[s].dst = nxt[s].dst + (DST_W'(pipe[s-1].pp[i]) << (CHUNK * i));
        end
        // padding taps and bad requests carry no source; bad requests no destination
        if (pipe[s-1].err || !pipe[s-1].in_img) begin
          nxt[s].src = '0;
        end
        if (pipe[s-1].err) begin
          nxt[s].dst = '0;
        end
        nxt[s].in_img = pipe[s-1].in_img && !pipe[s-1].err;
      end
    end
  end

  assign rsp.valid          = v[N-1];
  assign rsp.source_address = pipe[N-1].src;
  assign rsp.dest_address   = pipe[N-1].dst;
  assign rsp.inside_image   = pipe[N-1].in_img;
  assign rsp.request_error  = pipe[N-1].err;

  // input backpressure only when every stage is full and the result is stalled
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (rsp.valid && !rsp.ready && (&v)))
    else $error("input stalled while the pipe has room");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.request_error) |->
      (!rsp.inside_image && rsp.source_address == '0 && rsp.dest_address == '0))
    else $error("error beat carries addresses");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.inside_image) |-> (rsp.source_address == '0))
    else $error("padding beat carries a source address");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v[S_MUL] && !en[S_MUL]) |=> (v[S_MUL] && $stable(pipe[S_MUL].err)))
    else $error("stalled stage lost its beat");

endmodule

`default_nettype wire

>>> dv/i3ag_addr_checker.sv
// i3ag_addr_checker: watches the request, result and register ports of the 3-D im2col
// address generator, predicts each result beat and compares it. Needs i3ag_pkg, i3ag_if.
module i3ag_addr_checker import i3ag_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  i3ag_req_if                  req,
  i3ag_rsp_if                  rsp,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PACK_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int MAX_BATCH_TB = DEF_MAX_BATCH;

  typedef struct {
    logic [SRC_W-1:0] source_address;
    logic [DST_W-1:0] dest_address;
    logic             inside_image;
    logic             request_error;
  } addr_beat_t;

  cfg_regs_t  regs;
  addr_beat_t expected_addrs[$];
  int         fails;

  assign fail_count = fails;

  function automatic longint lane(logic [PACK_W-1:0] packed_reg, int which);
    return longint'({56'd0, packed_reg[8*which +: 8]});
  endfunction

  function automatic longint extent(longint size, longint k, longint s, longint p,
                                    longint dil);
    longint num;
    num = size + 2 * p - dil * (k - 1) - 1;
    if (k < 1 || num < 0) return 0;
    return num / s + 1;
  endfunction

  function automatic addr_beat_t predict_addr(logic [BATCH_W-1:0] b, logic [ROW_W-1:0] row,
                                              logic [POS_W-1:0] od_in, logic [POS_W-1:0] oh_in,
                                              logic [POS_W-1:0] ow_in);
    longint     kd, kr, kc, sd, sr, sc, pd, pr, pc, dd, dr, dc;
    longint     dim_d, dim_h, dim_w, ed, eh, ew, od, oh, ow, id, ih, iw;
    logic [63:0] b64, row64, cc, hh, ww, dp, kvol, rows, ci, offd, offh, offw;
    logic [63:0] hwc, dhwc, dst, hw, dhw, src;
    addr_beat_t r;
    kd = lane(regs.kernel_sizes, DIM_DEP); kr = lane(regs.kernel_sizes, DIM_ROW);
    kc = lane(regs.kernel_sizes, DIM_COL);
    sd = lane(regs.strides, DIM_DEP); sr = lane(regs.strides, DIM_ROW);
    sc = lane(regs.strides, DIM_COL);
    pd = lane(regs.paddings, DIM_DEP); pr = lane(regs.paddings, DIM_ROW);
    pc = lane(regs.paddings, DIM_COL);
    dd = lane(regs.dilations, DIM_DEP); dr = lane(regs.dilations, DIM_ROW);
    dc = lane(regs.dilations, DIM_COL);
    // a zero stride acts as one
    if (sd == 0) sd = 1;
    if (sr == 0) sr = 1;
    if (sc == 0) sc = 1;
    cc = {53'd0, regs.channel_count};
    dp = {53'd0, regs.image_depth};
    hh = {53'd0, regs.image_height};
    ww = {53'd0, regs.image_width};
    dim_d = longint'(dp); dim_h = longint'(hh); dim_w = longint'(ww);
    ed = extent(dim_d, kd, sd, pd, dd);
    eh = extent(dim_h, kr, sr, pr, dr);
    ew = extent(dim_w, kc, sc, pc, dc);
    kvol = 64'(kd) * 64'(kr) * 64'(kc);
    rows = cc * kvol;
    b64 = {56'd0, b};
    row64 = {40'd0, row};
    od = longint'({54'd0, od_in}); oh = longint'({54'd0, oh_in});
    ow = longint'({54'd0, ow_in});
    r = '{default: '0};
    if (b64 >= 64'(MAX_BATCH_TB) || row64 >= rows || od >= ed || oh >= eh || ow >= ew) begin
      r.request_error = 1'b1;
      return r;
    end
    offw = row64 % 64'(kc);
    offh = (row64 / 64'(kc)) % 64'(kr);
    offd = (row64 / 64'(kc) / 64'(kr)) % 64'(kd);
    ci = row64 / kvol;
    hwc = 64'(eh) * 64'(ew);
    dhwc = 64'(ed) * hwc;
    dst = b64 * rows * dhwc + row64 * dhwc + 64'(od) * hwc + 64'(oh) * 64'(ew) + 64'(ow);
    r.dest_address = dst[DST_W-1:0];
    id = od * sd - pd + longint'(offd) * dd;
    ih = oh * sr - pr + longint'(offh) * dr;
    iw = ow * sc - pc + longint'(offw) * dc;
    if (id >= 0 && id < dim_d && ih >= 0 && ih < dim_h && iw >= 0 && iw < dim_w) begin
      hw = hh * ww;
      dhw = dp * hw;
      src = b64 * cc * dhw + ci * dhw + 64'(id) * hw + 64'(ih) * ww + 64'(iw);
      r.source_address = src[SRC_W-1:0];
      r.inside_image = 1'b1;
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got %0h, want %0h", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    addr_beat_t want;
    if (rst) begin
      regs <= CFG_RESET;
      expected_addrs.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_e'(cfg_index))
          REG_CHANNEL_COUNT: regs.channel_count <= cfg_data[DIM_W-1:0];
          REG_IMAGE_DEPTH:   regs.image_depth   <= cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT:  regs.image_height  <= cfg_data[DIM_W-1:0];
          REG_IMAGE_WIDTH:   regs.image_width   <= cfg_data[DIM_W-1:0];
          REG_KERNEL_SIZES:  regs.kernel_sizes  <= cfg_data;
          REG_STRIDES:       regs.strides       <= cfg_data;
          REG_PADDINGS:      regs.paddings      <= cfg_data;
          REG_DILATIONS:     regs.dilations     <= cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        expected_addrs.push_back(predict_addr(req.batch_index, req.column_row,
                                              req.out_depth, req.out_row, req.out_col));
      if (rsp.valid && rsp.ready) begin
        if (expected_addrs.size() == 0) begin
          report("result beat with nothing expected", 64'(rsp.dest_address), 64'd0);
        end else begin
          want = expected_addrs.pop_front();
          if (rsp.source_address !== want.source_address)
            report("source_address", 64'(rsp.source_address), 64'(want.source_address));
          if (rsp.dest_address !== want.dest_address)
            report("dest_address", 64'(rsp.dest_address), 64'(want.dest_address));
          if (rsp.inside_image !== want.inside_image)
            report("inside_image", 64'(rsp.inside_image), 64'(want.inside_image));
          if (rsp.request_error !== want.request_error)
            report("request_error", 64'(rsp.request_error), 64'(want.request_error));
        end
      end
    end
    pending <= expected_addrs.size();
  end

endmodule

>>> dv/tb_im2col_3d_address_generator.sv
// tb_im2col_3d_address_generator: drives requests, register writes and result back-pressure
// into the address generator; i3ag_addr_checker does the checking. Needs src/ and the checker.
module tb_im2col_3d_address_generator;
  import i3ag_pkg::*;

  localparam int NUM_PHASES = 9;
  localparam int RAND_PER_PHASE = 105;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PACK_W-1:0]    cfg_data;
  int                   fail_count;
  int                   pending;
  int                   sent;
  bit                   no_idle;
  bit                   long_hold;
  logic [PACK_W-1:0]    cur_regs[8];

  i3ag_req_if req();
  i3ag_rsp_if rsp();

  im2col_3d_address_generator DUT (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  i3ag_addr_checker checker_i (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 400000);
    $display("im2col_3d_address_generator: mismatch");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, plus one long hold that lets the pipe fill
  initial begin
    int gap_left, hold_left;
    gap_left = 0;
    hold_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (long_hold) begin
        long_hold = 1'b0;
        hold_left = 200;
        rsp.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) gap_left = gap_len();
      end
    end
  end

  task automatic send(logic [BATCH_W-1:0] b, logic [ROW_W-1:0] row, logic [POS_W-1:0] od,
                      logic [POS_W-1:0] oh, logic [POS_W-1:0] ow);
    int gap;
    req.valid       <= 1'b1;
    req.batch_index <= b;
    req.column_row  <= row;
    req.out_depth   <= od;
    req.out_row     <= oh;
    req.out_col     <= ow;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
    gap = gap_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [POS_W-1:0] pick_pos(logic [PACK_W-1:0] dim, int which);
    int bound;
    bound = dim + 2 * cur_regs[REG_PADDINGS][8*which +: 8];
    if (bound > 1023) bound = 1023;
    return POS_W'($urandom_range(0, bound));
  endfunction

  // mostly in-range requests; one in ten is fully random noise
  task automatic send_random();
    longint rows;
    longint row_max;
    logic [PACK_W-1:0] ks;
    ks = cur_regs[REG_KERNEL_SIZES];
    rows = longint'(cur_regs[REG_CHANNEL_COUNT][DIM_W-1:0]) * ks[7:0] * ks[15:8] * ks[23:16];
    row_max = (rows + 2 > 24'hFFFFFF) ? 24'hFFFFFF : rows + 2;
    if ($urandom_range(0, 9) == 0)
      send(BATCH_W'($urandom), ROW_W'($urandom), POS_W'($urandom), POS_W'($urandom),
           POS_W'($urandom));
    else
      send(BATCH_W'($urandom), ROW_W'($urandom_range(0, int'(row_max))),
           pick_pos(cur_regs[REG_IMAGE_DEPTH], DIM_DEP),
           pick_pos(cur_regs[REG_IMAGE_HEIGHT], DIM_ROW),
           pick_pos(cur_regs[REG_IMAGE_WIDTH], DIM_COL));
  endtask

  // lower valid, let every result come back, then sit out the pipe latency
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic load_cfg(logic [PACK_W-1:0] c, logic [PACK_W-1:0] d, logic [PACK_W-1:0] h,
                          logic [PACK_W-1:0] w, logic [PACK_W-1:0] ks, logic [PACK_W-1:0] st,
                          logic [PACK_W-1:0] pd, logic [PACK_W-1:0] dl);
    cur_regs = '{c, d, h, w, ks, st, pd, dl};
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= cur_regs[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    for (int i = 0; i < 4; i++) cur_regs[i] = cur_regs[i] & 24'h7FF;
    // derived extents need time to settle
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.batch_index = '0;
    req.column_row = '0;
    req.out_depth = '0;
    req.out_row = '0;
    req.out_col = '0;
    sent = 0;
    no_idle = 1'b0;
    long_hold = 1'b0;
    cur_regs = '{24'd1, 24'd1, 24'd1, 24'd1, 24'h010101, 24'h010101, 24'h0, 24'h010101};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (16) @(posedge clk);

    // reset configuration: a single valid tap per batch; an out-of-range row or position is an error
    send(8'd0, 24'd0, 10'd0, 10'd0, 10'd0);
    send(8'd255, 24'd0, 10'd0, 10'd0, 10'd0);
    send(8'd0, 24'd1, 10'd0, 10'd0, 10'd0);
    send(8'd0, 24'd0, 10'd1, 10'd0, 10'd0);
    send(8'd0, 24'hFFFFFF, 10'h3FF, 10'h3FF, 10'h3FF);
    drain();

    for (int phase = 1; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: load_cfg(3, 5, 6, 7, 24'h030303, 24'h010101, 24'h010101, 24'h010101);
        2: load_cfg(1024, 1024, 1024, 1024, 24'h010101, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        3: load_cfg(1024, 1024, 1024, 1024, 24'hFFFFFF, 24'h010101, 24'hFFFFFF, 24'h010101);
        4: load_cfg(2, 4, 4, 4, 24'h020302, 24'h000000, 24'h010001, 24'h000100);
        5: load_cfg(4, 8, 8, 8, 24'h000000, 24'h010101, 24'h000000, 24'h010101);
        6: load_cfg(2, 0, 3, 3, 24'h010101, 24'h010101, 24'h010101, 24'h010101);
        7: load_cfg(0, 2, 9, 9, 24'h030305, 24'h010101, 24'h000000, 24'h010101);
        default: load_cfg(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h020202,
                          24'h030201, 24'h020100, 24'h010203);
      endcase
      no_idle = phase[0];
      if (phase == 1) begin
        // corners of the 3x3x3, pad 1 case: last row, last positions, one past each
        send(8'd0, 24'd80, 10'd4, 10'd5, 10'd6);
        send(8'd255, 24'd80, 10'd0, 10'd0, 10'd0);
        send(8'd1, 24'd81, 10'd0, 10'd0, 10'd0);
        send(8'd0, 24'd0, 10'd5, 10'd0, 10'd0);
        send(8'd0, 24'd0, 10'd0, 10'd6, 10'd0);
        send(8'd0, 24'd0, 10'd0, 10'd0, 10'd7);
        send(8'd2, 24'd40, 10'd2, 10'd3, 10'd3);
        send(8'd7, 24'd26, 10'd0, 10'd0, 10'd6);
        send(8'hAA, 24'h555555, 10'h155, 10'h2AA, 10'h155);
        send(8'h55, 24'hAAAAAA, 10'h2AA, 10'h155, 10'h2AA);
        long_hold = 1'b1;
      end
      repeat (RAND_PER_PHASE) send_random();
      drain();
    end

    $display("%0d requests over %0d register settings: padding, zero stride/dilation,",
             sent, NUM_PHASES);
    $display("empty extents, zero kernel/channels, address wrap and back-pressure");
    if (fail_count == 0)
      $display("im2col_3d_address_generator: match");
    else
      $display("im2col_3d_address_generator: mismatch");
    $finish;
  end

endmodule
